// ===== rtl/core/csfs_pkg.sv =====
`timescale 1ns / 1ps

package csfs_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] SKIP_MAX   = 16'hFFFF;
    localparam logic [2:0]  BIT_LAST   = 3'd7;
    localparam int          SCAN_CHUNK = 32;
    localparam int          CHUNK_BITS = $clog2(SCAN_CHUNK);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_CMP,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift;
        logic fold;
        logic compare;
        logic flush;
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;
        logic [7:0] addr_byte;
        logic [7:0] func_byte;
    } scan_hit_t;

    typedef struct packed {
        logic [15:0] skipped_bytes;
        logic [8:0]  frame_length;
        logic [7:0]  slave_address;
        logic [6:0]  function_code;
        logic        is_exception;
        logic [15:0] frame_crc;
    } result_t;

endpackage

// ===== rtl/core/csfs_if.sv =====
`timescale 1ns / 1ps

interface csfs_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface csfs_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] skipped_bytes;
    logic [8:0]  frame_length;
    logic [7:0]  slave_address;
    logic [6:0]  function_code;
    logic        is_exception;
    logic [15:0] frame_crc;

    modport source (
        output valid, output skipped_bytes, output frame_length, output slave_address,
        output function_code, output is_exception, output frame_crc, input ready
    );
    modport sink (
        input valid, input skipped_bytes, input frame_length, input slave_address,
        input function_code, input is_exception, input frame_crc, output ready
    );
endinterface

// ===== rtl/core/csfs_cells.sv =====
`timescale 1ns / 1ps

module csfs_cells #(
    parameter int WINDOW_BYTES   = 256,
    parameter int MIN_DATA_BYTES = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csfs_pkg::cell_ctrl_t              ctrl,
    input  logic [7:0]                        rx_byte,
    output logic [WINDOW_BYTES-1:0]           match,
    output logic [WINDOW_BYTES-1:0][7:0]      window_bytes,
    output logic [15:0]                       tail
);
    import csfs_pkg::*;

    // Cell k holds the byte received k items ago and the CRC of the frame that starts there.
    logic [WINDOW_BYTES-1:0][7:0]  byte_reg;
    logic [WINDOW_BYTES-1:0][7:0]  byte_next;
    logic [WINDOW_BYTES-1:0][15:0] crc_reg;
    logic [WINDOW_BYTES-1:0][15:0] crc_next;
    logic [WINDOW_BYTES-1:0]       valid_reg;
    logic [WINDOW_BYTES-1:0]       match_reg;
    logic [WINDOW_BYTES-1:0]       match_next;
    logic [7:0]                    fold_sr_reg;

    function automatic logic [15:0] crc_bit_step(input logic [15:0] crc, input logic din);
        logic fb;
        fb = crc[0] ^ din;
        return {1'b0, crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    endfunction

    assign tail = {byte_reg[0], byte_reg[1]};

    always_comb
    begin
        byte_next[0] = ctrl.shift ? rx_byte : byte_reg[0];
        crc_next[0]  = ctrl.shift ? CRC_INIT : crc_reg[0];
        for (int k = 1; k < WINDOW_BYTES; k++)
        begin
            byte_next[k] = byte_reg[k];
            crc_next[k]  = crc_reg[k];
            if (ctrl.shift)
            begin
                byte_next[k] = byte_reg[k-1];
                crc_next[k]  = crc_reg[k-1];
            end
            else if (ctrl.fold && valid_reg[k] && (k >= 2))
            begin
                // fold one bit of the byte that sits two places behind the newest
                crc_next[k] = crc_bit_step(crc_reg[k], fold_sr_reg[0]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            match_next[k] = valid_reg[k] && (k > MIN_DATA_BYTES) && (crc_reg[k] == tail);
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        crc_reg  <= crc_next;
        if (ctrl.shift)
        begin
            // after the shift, cell 1 moves into the fold position
            fold_sr_reg <= byte_reg[1];
        end
        else if (ctrl.fold)
        begin
            fold_sr_reg <= {1'b0, fold_sr_reg[7:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            match_reg <= '0;
        end
        else
        begin
            if (ctrl.flush)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                valid_reg <= {valid_reg[WINDOW_BYTES-2:0], 1'b1};
            end
            if (ctrl.compare)
            begin
                match_reg <= match_next;
            end
        end
    end

    assign match        = match_reg;
    assign window_bytes = byte_reg;

`ifndef NO_ASSERTIONS
    a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_reg & ~(valid_reg >> 1)))
        else $error("cell valid bits are not contiguous from the newest cell");

    a_ctrl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctrl))
        else $error("more than one cell operation in a cycle");

    a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[WINDOW_BYTES-1] && ctrl.shift) |=> valid_reg[WINDOW_BYTES-1])
        else $error("shift into a full window lost the oldest valid cell");
`endif

endmodule

// ===== rtl/core/csfs_scan.sv =====
`timescale 1ns / 1ps

module csfs_scan #(
    parameter int WINDOW_BYTES = 256
) (
    input  logic [WINDOW_BYTES-1:0]                  match,
    input  logic [WINDOW_BYTES-1:0][7:0]             window_bytes,
    input  logic [((((WINDOW_BYTES + csfs_pkg::SCAN_CHUNK - 1) / csfs_pkg::SCAN_CHUNK) > 1)
                  ? $clog2((WINDOW_BYTES + csfs_pkg::SCAN_CHUNK - 1) / csfs_pkg::SCAN_CHUNK)
                  : 1) - 1:0]                         grp,
    output csfs_pkg::scan_hit_t                      hit,
    output logic [$clog2(WINDOW_BYTES)-1:0]          hit_age
);
    import csfs_pkg::*;

    localparam int GROUPS = (WINDOW_BYTES + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PW     = GW + CHUNK_BITS;
    localparam int NP     = 1 << PW;
    localparam int AW     = $clog2(WINDOW_BYTES);
    localparam int SELW   = CHUNK_BITS + 1;

    logic [NP-1:0]               match_pad;
    logic [NP-1:0][7:0]          byte_pad;
    logic [PW-1:0]               base;
    logic [SCAN_CHUNK-1:0]       grp_match;
    // grp_bytes[c] holds the byte at age base + c - 1
    logic [SCAN_CHUNK:0][7:0]    grp_bytes;
    logic [CHUNK_BITS-1:0]       sel;
    logic [SELW-1:0]             sel_ext;

    always_comb
    begin
        match_pad                 = '0;
        match_pad[WINDOW_BYTES-1:0] = match;
        byte_pad                  = '0;
        byte_pad[WINDOW_BYTES-1:0] = window_bytes;
    end

    always_comb
    begin
        base = {grp, {CHUNK_BITS{1'b0}}};
        for (int c = 0; c < SCAN_CHUNK; c++)
        begin
            grp_match[c] = match_pad[base + PW'(c)];
        end
        for (int c = 0; c <= SCAN_CHUNK; c++)
        begin
            grp_bytes[c] = byte_pad[base + PW'(c) - PW'(1)];
        end
    end

    // the oldest matching cell, i.e. the earliest frame start, wins
    always_comb
    begin
        hit.hit = 1'b0;
        sel     = '0;
        for (int c = 0; c < SCAN_CHUNK; c++)
        begin
            if (grp_match[c])
            begin
                hit.hit = 1'b1;
                sel     = CHUNK_BITS'(c);
            end
        end
        sel_ext       = {1'b0, sel};
        hit.addr_byte = grp_bytes[sel_ext + SELW'(1)];
        hit.func_byte = grp_bytes[sel_ext];
        hit_age       = AW'({grp, sel});
    end

endmodule

// ===== rtl/core/csfs_ctrl.sv =====
`timescale 1ns / 1ps

module csfs_ctrl #(
    parameter int WINDOW_BYTES   = 256,
    parameter int MIN_DATA_BYTES = 3
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output csfs_pkg::result_t                        result,
    output csfs_pkg::cell_ctrl_t                     cell_ctrl,
    output logic [((((WINDOW_BYTES + csfs_pkg::SCAN_CHUNK - 1) / csfs_pkg::SCAN_CHUNK) > 1)
                   ? $clog2((WINDOW_BYTES + csfs_pkg::SCAN_CHUNK - 1) / csfs_pkg::SCAN_CHUNK)
                   : 1) - 1:0]                       grp,
    input  csfs_pkg::scan_hit_t                      hit,
    input  logic [$clog2(WINDOW_BYTES)-1:0]          hit_age,
    input  logic [15:0]                              tail
);
    import csfs_pkg::*;

    localparam int GROUPS = (WINDOW_BYTES + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int AW     = $clog2(WINDOW_BYTES);
    localparam int LW     = AW + 1;
    localparam int CW     = $clog2(WINDOW_BYTES + 1);

    state_t          state_reg;
    state_t          state_next;
    logic [2:0]      bit_cnt_reg;
    logic [GW-1:0]   grp_reg;
    logic [CW-1:0]   fill_reg;
    logic [15:0]     skip_reg;
    result_t         hold_reg;
    result_t         out_reg;
    logic            out_valid_reg;

    logic            in_fire;
    logic            full;
    logic            enough;
    logic            emit_load;
    logic [CW-1:0]   start_ofs;
    logic [16:0]     skip_sum;
    logic [LW-1:0]   len_full;

    assign in_fire = in_valid && in_ready;
    assign full    = (fill_reg == CW'(WINDOW_BYTES));
    assign enough  = (fill_reg >= CW'(MIN_DATA_BYTES + 2));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (bit_cnt_reg == BIT_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = enough ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit.hit)
                begin
                    state_next = ST_EMIT;
                end
                else if (grp_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        cell_ctrl.shift   = (state_reg == ST_IDLE) && in_valid;
        cell_ctrl.fold    = (state_reg == ST_FOLD);
        cell_ctrl.compare = (state_reg == ST_CMP);
        cell_ctrl.flush   = (state_reg == ST_SCAN) && hit.hit;
        emit_load         = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    // frame start offset counted from the oldest byte in the window
    always_comb
    begin
        start_ofs = fill_reg - CW'(1) - CW'(hit_age);
        skip_sum  = 17'(skip_reg) + 17'(start_ofs);
        len_full  = {1'b0, hit_age} + LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            grp_reg       <= '0;
            fill_reg      <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= (state_reg == ST_FOLD) ? bit_cnt_reg + 3'd1 : 3'd0;

            if (state_reg == ST_CMP)
            begin
                grp_reg <= GW'(GROUPS - 1);
            end
            else if (state_reg == ST_SCAN)
            begin
                grp_reg <= grp_reg - GW'(1);
            end

            if (cell_ctrl.flush)
            begin
                fill_reg <= '0;
                skip_reg <= '0;
            end
            else if (in_fire)
            begin
                if (full)
                begin
                    // oldest byte falls off the end of the window
                    if (skip_reg != SKIP_MAX)
                    begin
                        skip_reg <= skip_reg + 16'd1;
                    end
                end
                else
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_ctrl.flush)
        begin
            hold_reg.skipped_bytes <= skip_sum[16] ? SKIP_MAX : skip_sum[15:0];
            hold_reg.frame_length  <= 9'(len_full);
            hold_reg.slave_address <= hit.addr_byte;
            hold_reg.function_code <= hit.func_byte[6:0];
            hold_reg.is_exception  <= hit.func_byte[7];
            hold_reg.frame_crc     <= tail;
        end
        if (emit_load)
        begin
            out_reg <= hold_reg;
        end
    end

    assign grp       = grp_reg;
    assign result    = out_reg;
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_FOLD))
        else $error("accepted item did not start the CRC fold");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_BYTES))
        else $error("fill count beyond window size");

    a_hit_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit.hit) |=>
        (fill_reg == '0 && skip_reg == '0 && state_reg == ST_EMIT))
        else $error("found frame did not consume the window");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !out_ready) |=>
        (state_reg == ST_EMIT && out_valid_reg))
        else $error("result overwrote an item not yet taken");
`endif

endmodule

// ===== rtl/core/crc_search_frame_sync_top.sv =====
`timescale 1ns / 1ps
// Flow: an accepted byte is shifted into the window, the bit-serial CRC fold (ST_FOLD) runs in
// the valid cells from cell 2 on, ST_CMP compares each cell's CRC with the tail and, once
// MIN_DATA_BYTES + 2 bytes are held, ST_SCAN checks 32 offsets per step from the oldest
// group down until a hit; ST_EMIT then loads the result, waiting while an earlier result is
// not yet taken. A new byte is taken only in ST_IDLE, once the previous byte's pass is done.
// Reset: asynchronous; the window empties and the skip count clears at once, no clearing pass.

module crc_search_frame_sync_top #(
    parameter int WINDOW_BYTES   = 256,
    parameter int MIN_DATA_BYTES = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    csfs_rx_if.sink      rx,
    csfs_res_if.source   res
);
    import csfs_pkg::*;

    localparam int GROUPS = (WINDOW_BYTES + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int AW     = $clog2(WINDOW_BYTES);

    cell_ctrl_t                     cell_ctrl;
    scan_hit_t                      hit;
    logic [AW-1:0]                  hit_age;
    logic [GW-1:0]                  grp;
    logic [WINDOW_BYTES-1:0]        match;
    logic [WINDOW_BYTES-1:0][7:0]   window_bytes;
    logic [15:0]                    tail;
    result_t                        result;
    logic                           in_ready;
    logic                           out_valid;

    csfs_cells #(
        .WINDOW_BYTES   (WINDOW_BYTES),
        .MIN_DATA_BYTES (MIN_DATA_BYTES)
    ) u_cells (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (cell_ctrl),
        .rx_byte      (rx.rx_byte),
        .match        (match),
        .window_bytes (window_bytes),
        .tail         (tail)
    );

    csfs_scan #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_scan (
        .match        (match),
        .window_bytes (window_bytes),
        .grp          (grp),
        .hit          (hit),
        .hit_age      (hit_age)
    );

    csfs_ctrl #(
        .WINDOW_BYTES   (WINDOW_BYTES),
        .MIN_DATA_BYTES (MIN_DATA_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (in_ready),
        .out_ready (res.ready),
        .out_valid (out_valid),
        .result    (result),
        .cell_ctrl (cell_ctrl),
        .grp       (grp),
        .hit       (hit),
        .hit_age   (hit_age),
        .tail      (tail)
    );

    assign rx.ready          = in_ready;
    assign res.valid         = out_valid;
    assign res.skipped_bytes = result.skipped_bytes;
    assign res.frame_length  = result.frame_length;
    assign res.slave_address = result.slave_address;
    assign res.function_code = result.function_code;
    assign res.is_exception  = result.is_exception;
    assign res.frame_crc     = result.frame_crc;

endmodule
